// File: src/xs128_pkg.sv
// ----------------------------------------------------------------------------
// xs128_pkg
// Shared types and constants of the xorshift128 generator: controller states,
// command and status groups, and the seed expansion and shift constants.
// ----------------------------------------------------------------------------
package xs128_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned BoundW  = 31;
    localparam int unsigned CntW    = 5;
    localparam int unsigned DivLast = WordW - 1;
    localparam int unsigned SeedLast = 3;

    localparam logic [WordW-1:0] SEED_MULT = 32'd1812433253;
    localparam int unsigned SEED_SHIFT = 30;
    localparam int unsigned XS_SHL_A   = 11;
    localparam int unsigned XS_SHR_D   = 19;
    localparam int unsigned XS_SHR_T   = 8;

    typedef enum logic [2:0] {
        S_SEED_MUL,
        S_SEED_ADD,
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       seed_load;
        logic       seed_mul;
        logic       seed_add;
        logic [2:0] seed_k;
        logic       accept;
        logic       div_step;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic bnd_zero;
        logic out_free;
    } t_sts;

endpackage

// File: src/xs128_ctrl.sv
// ----------------------------------------------------------------------------
// xs128_ctrl
// Controller: seeds the state after reset or a seed write, admits one request
// at a time, steps the remainder unit and hands the result to the output.
// ----------------------------------------------------------------------------
module xs128_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  xs128_pkg::t_sts  i_sts,
    output xs128_pkg::t_cmd  o_cmd
);
    import xs128_pkg::*;

    t_state           r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             w_accept;

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SEED_MUL;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_cmd           = '0;
        o_cmd.seed_k    = {1'b0, r_cnt[1:0]} + 3'd1;
        o_cmd.seed_load = i_cfg_we;
        if (i_cfg_we) begin
            // restart expansion from the freshly written seed
            n_state = S_SEED_MUL;
            n_cnt   = '0;
        end else begin
            unique case (r_state)
                S_SEED_MUL: begin
                    o_cmd.seed_mul = 1'b1;
                    n_state        = S_SEED_ADD;
                end
                S_SEED_ADD: begin
                    o_cmd.seed_add = 1'b1;
                    if (r_cnt == CntW'(SeedLast)) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_state = S_SEED_MUL;
                        n_cnt   = r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        o_cmd.accept = 1'b1;
                        n_state      = S_DIV;
                        n_cnt        = '0;
                    end
                end
                S_DIV: begin
                    if (i_sts.bnd_zero) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.div_step = 1'b1;
                        n_cnt          = r_cnt + 1'b1;
                        if (r_cnt == CntW'(DivLast)) begin
                            n_state = S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (i_sts.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_SEED_MUL;
                    n_cnt   = '0;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_DIV) && (r_cnt == '0))
        else $error("accepted transaction did not start the remainder unit");

    a_seed_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == S_SEED_MUL) && (r_cnt == '0))
        else $error("seed write did not restart expansion");

    a_seed_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED_ADD) && (r_cnt == CntW'(SeedLast)) && !i_cfg_we
        |=> (r_state == S_IDLE))
        else $error("expansion did not finish after the fourth word");
`endif

endmodule

// File: src/xs128_dp.sv
// ----------------------------------------------------------------------------
// xs128_dp
// Datapath: the four generator words, the seed expansion multiplier, the
// bit-serial remainder unit and the output register.
// ----------------------------------------------------------------------------
module xs128_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [xs128_pkg::WordW-1:0]        i_cfg_wdata,
    input  logic [xs128_pkg::BoundW-1:0]       i_bound,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [xs128_pkg::WordW-1:0]        o_value,
    input  xs128_pkg::t_cmd                    i_cmd,
    output xs128_pkg::t_sts                    o_sts
);
    import xs128_pkg::*;

    logic [WordW-1:0]  r_wa, r_wb, r_wc, r_wd;
    logic [WordW-1:0]  r_s;
    logic [WordW-1:0]  r_prod;
    logic [WordW-1:0]  r_dvd;
    logic [BoundW-1:0] r_bnd;
    logic [BoundW-1:0] r_rem;
    logic [WordW-1:0]  r_out;
    logic              r_out_valid;

    logic [WordW-1:0]  w_t;
    logic [WordW-1:0]  w_next_d;
    logic [WordW-1:0]  w_seed_new;
    logic [WordW-1:0]  w_trial;
    logic [WordW-1:0]  w_diff;
    logic              w_ge;

    assign w_t        = r_wa ^ (r_wa << XS_SHL_A);
    assign w_next_d   = (r_wd ^ (r_wd >> XS_SHR_D)) ^ (w_t ^ (w_t >> XS_SHR_T));
    assign w_seed_new = r_prod + {{(WordW-3){1'b0}}, i_cmd.seed_k};

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[WordW-1]};
    assign w_ge    = w_trial >= {1'b0, r_bnd};
    assign w_diff  = w_trial - {1'b0, r_bnd};

    assign o_sts.bnd_zero = (r_bnd == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_value        = r_out;

    // seed chain: r_s is the seed register itself at reset and after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (i_cmd.seed_load) begin
            r_s <= i_cfg_wdata;
        end else if (i_cmd.seed_add) begin
            r_s <= w_seed_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_mul) begin
            r_prod <= SEED_MULT * (r_s ^ (r_s >> SEED_SHIFT));
        end
    end

    // generator words: expansion shifts words in from the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_add) begin
            r_wa <= r_wb;
            r_wb <= r_wc;
            r_wc <= r_wd;
            r_wd <= w_seed_new;
        end else if (i_cmd.accept) begin
            r_wa <= r_wb;
            r_wb <= r_wc;
            r_wc <= r_wd;
            r_wd <= w_next_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dvd <= w_next_d;
            r_bnd <= i_bound;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_ge ? w_diff[BoundW-1:0] : w_trial[BoundW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= (r_bnd == '0) ? r_wd : {1'b0, r_rem};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_raw_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && (r_bnd == '0) |=> (r_out == r_wd))
        else $error("raw request did not return the new word");

    a_mod_below_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && (r_bnd != '0) |=> (r_out < {1'b0, r_bnd}))
        else $error("remainder not below bound");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step && (r_bnd != '0) |-> (r_rem < r_bnd))
        else $error("partial remainder out of range");
`endif

endmodule

// File: src/xorshift128_random_generator.sv
// ----------------------------------------------------------------------------
// xorshift128_random_generator
// Xorshift128 pseudo-random word source with optional reduction modulo a
// per-request bound.
// ----------------------------------------------------------------------------
// One request is handled at a time. A transaction with bound 0 returns the raw
// 32-bit word without stepping the remainder unit; a nonzero bound runs the
// bit-serial remainder unit, one dividend bit per cycle, and the next request is
// taken on the cycle after the result enters the output register. The output
// register lets a finished result wait for the consumer while the next request
// is already accepted. After reset, and after every seed write, four expansion
// steps (a multiply, then an add) refill the state while the input stalls.
// The seed port takes a write on any cycle with i_cfg_we high; write it only
// while no request is in flight.
// ----------------------------------------------------------------------------
module xorshift128_random_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // seed register
    input  logic                          i_cfg_we,
    input  logic [xs128_pkg::WordW-1:0]   i_cfg_wdata,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [xs128_pkg::BoundW-1:0]  i_bound,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [xs128_pkg::WordW-1:0]   o_value
);
    import xs128_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // controller: sequencing of seeding, admission and the remainder steps
    xs128_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: state words, expansion multiplier, remainder unit, output hold
    xs128_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wdata (i_cfg_wdata),
        .i_bound     (i_bound),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// File: dv/xorshift128_random_generator_tb.sv
// ----------------------------------------------------------------------------
// xorshift128_random_generator_tb
// Self-checking bench for the xorshift128 generator. Drive bounded and raw
// requests under several seeds, predict every word with a local copy of the
// generator state, and compare each returned value in order of acceptance.
// ----------------------------------------------------------------------------
class xs128_word_tracker;

    logic [xs128_pkg::WordW-1:0] word_a;
    logic [xs128_pkg::WordW-1:0] word_b;
    logic [xs128_pkg::WordW-1:0] word_c;
    logic [xs128_pkg::WordW-1:0] word_d;
    logic [xs128_pkg::WordW-1:0] awaited_values[$];
    int unsigned                 mismatches;

    function new();
        mismatches = 0;
        seed_words('0);
    endfunction

    // Refill the four words from a seed by the chained expansion steps
    function void seed_words(input logic [xs128_pkg::WordW-1:0] seed_val);
        logic [xs128_pkg::WordW-1:0] s;
        logic [xs128_pkg::WordW-1:0] fill[4];
        s = seed_val;
        for (int k = 1; k <= 4; k++) begin
            s = xs128_pkg::SEED_MULT * (s ^ (s >> xs128_pkg::SEED_SHIFT))
                + xs128_pkg::WordW'(k);
            fill[k-1] = s;
        end
        word_a = fill[0];
        word_b = fill[1];
        word_c = fill[2];
        word_d = fill[3];
    endfunction

    // Advance one xorshift step and queue the value the request must return
    function void note_request(input logic [xs128_pkg::BoundW-1:0] bnd);
        logic [xs128_pkg::WordW-1:0] t;
        t      = word_a ^ (word_a << xs128_pkg::XS_SHL_A);
        word_a = word_b;
        word_b = word_c;
        word_c = word_d;
        word_d = (word_d ^ (word_d >> xs128_pkg::XS_SHR_D)) ^ (t ^ (t >> xs128_pkg::XS_SHR_T));
        if (bnd == '0) begin
            awaited_values.push_back(word_d);
        end else begin
            awaited_values.push_back(word_d % {1'b0, bnd});
        end
    endfunction

    function void check_value(input logic [xs128_pkg::WordW-1:0] got);
        logic [xs128_pkg::WordW-1:0] want;
        if (awaited_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: value %h returned with no request outstanding", got);
            end
            return;
        end
        want = awaited_values.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: value mismatch, expected %h, got %h", want, got);
            end
        end
    endfunction

    function int unsigned outstanding();
        return awaited_values.size();
    endfunction

endclass

module xorshift128_random_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import xs128_pkg::*;

    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned PHASE_ITEMS = 205;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [WordW-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [BoundW-1:0] i_bound     = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [WordW-1:0]  o_value;

    xs128_word_tracker tracker;

    // Per-phase switches: drop the random gaps on one side or both
    bit calm_in        = 1'b0;
    bit calm_out       = 1'b0;
    // Ask the result side for one long hold-off
    bit long_hold_req  = 1'b0;

    xorshift128_random_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_bound     (i_bound),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Offer one request after a random gap; hold valid and bound until the
    // transaction is taken. Valid stays high on exit so back-to-back requests
    // need no drop.
    task automatic offer_request(input logic [BoundW-1:0] bnd);
        int unsigned gap;
        gap = calm_in ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_bound    <= bnd;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(bnd);
    endtask

    // Drop the request valid and wait until every outstanding value is back
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the seed only once the block is quiet; the generator then
    // refills its words and stalls the request side on its own
    task automatic write_seed(input logic [WordW-1:0] seed_val);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed_val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.seed_words(seed_val);
    endtask

    // Result side: hold stall for a random count before each transaction,
    // or for a long stretch when asked, then take the next value
    task automatic collect_values();
        forever begin
            int unsigned hold;
            hold = calm_out ? 0 : $urandom_range(0, 8);
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            tracker.check_value(o_value);
        end
    endtask

    initial begin
        logic [BoundW-1:0] corner_bounds[12];
        logic [WordW-1:0]  seed_plan[6];
        logic [BoundW-1:0] bnd;

        tracker = new();

        // Bound corners: raw word, the smallest moduli, the largest, a lone
        // top bit and alternating patterns so every bit is seen at both values
        corner_bounds = '{31'd0, 31'd1, 31'd2, 31'd3, 31'h7FFF_FFFF, 31'h7FFF_FFFE,
                          31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAA, 31'h0001_0000,
                          31'd7, 31'd0};

        // An all-ones seed first, then rewrite the reset seed, then single-bit seeds, then random ones
        seed_plan = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
                      $urandom(), $urandom()};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            collect_values();
        join_none

        // Directed requests against the reset seed
        foreach (corner_bounds[i]) begin
            offer_request(corner_bounds[i]);
        end

        for (int phase = 0; phase <= 6; phase++) begin
            if (phase > 0) begin
                write_seed(seed_plan[phase-1]);
            end
            calm_in  = (phase == 2) || (phase == 5);
            calm_out = (phase == 3) || (phase == 5);
            // Hold the result side off while requests keep coming, so the
            // output register fills and the request side stalls
            if (phase == 1 || phase == 4) begin
                long_hold_req = 1'b1;
            end
            // Run the corners again under the first written seed
            if (phase == 1) begin
                foreach (corner_bounds[i]) begin
                    offer_request(corner_bounds[i]);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: bnd = '0;
                    3:       bnd = 31'h7FFF_FFFF - BoundW'($urandom_range(0, 3));
                    4:       bnd = BoundW'(1) << $urandom_range(0, BoundW-1);
                    5, 6:    bnd = BoundW'($urandom_range(1, 16));
                    default: bnd = BoundW'($urandom());
                endcase
                offer_request(bnd);
            end
        end

        // Drain, then give the block a little longer to show a stray value
        settle_block();
        repeat (40) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("PASS xorshift128_random_generator");
        end else begin
            $display("FAIL xorshift128_random_generator");
        end
        $finish;
    end

    // Bound the run well beyond the slowest legal completion
    initial begin
        #1_000_000;
        $display("FAIL xorshift128_random_generator");
        $finish;
    end

endmodule

// File: filelist.f
src/xs128_pkg.sv
src/xs128_ctrl.sv
src/xs128_dp.sv
src/xorshift128_random_generator.sv
dv/xorshift128_random_generator_tb.sv
